/* sv/arcade_drive_mixer_unit_assert.svh */
`ifndef ARCADE_DRIVE_MIXER_UNIT_ASSERT_SVH
`define ARCADE_DRIVE_MIXER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ADM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arcade drive mixer: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ADM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arcade drive mixer: next-cycle check failed");

`endif

/* sv/adm_pkg.sv */
package adm_pkg;

    // Default number of fraction bits of the normalised axis value
    localparam int FRAC_BITS_DEF = 15;

    // Quotient bits resolved in each divider stage
    localparam int DIV_BITS_PER_STAGE = 4;

    // Field widths
    localparam int RAW_W      = 8;
    localparam int CFG_W      = 8;
    localparam int DRIVE_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_CENTER = 2'd0,
        REG_DEADZONE    = 2'd1,
        REG_FULL_SCALE  = 2'd2,
        REG_TOP_SPEED   = 2'd3
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] AXIS_CENTER_RST = 8'd50;
    localparam logic [CFG_W-1:0] DEADZONE_RST    = 8'd5;
    localparam logic [CFG_W-1:0] FULL_SCALE_RST  = 8'd50;
    localparam logic [CFG_W-1:0] TOP_SPEED_RST   = 8'd255;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] axis_center;
        logic [CFG_W-1:0] deadzone;
        logic [CFG_W-1:0] full_scale;
        logic [CFG_W-1:0] top_speed;
    } cfg_t;

endpackage

/* sv/adm_shape.sv */
module adm_shape
#(
    parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEF,
    localparam int DIV_STAGES = (FRAC_BITS + adm_pkg::DIV_BITS_PER_STAGE - 1)
                                / adm_pkg::DIV_BITS_PER_STAGE,
    localparam int SHAPE_STAGES = DIV_STAGES + 3
)
(
    input  logic                           clk,
    input  logic [SHAPE_STAGES-1:0]        en,
    input  logic [adm_pkg::RAW_W-1:0]      raw,
    input  adm_pkg::cfg_t                  cfg,
    output logic signed [FRAC_BITS+1:0]    cube
);

    localparam int NW  = FRAC_BITS + 1;
    localparam int PW  = 2 * NW;
    localparam int BPS = adm_pkg::DIV_BITS_PER_STAGE;
    localparam logic [NW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Front end and divider stages
    logic [7:0]           rem_reg  [0:DIV_STAGES];
    logic [7:0]           rem_next [0:DIV_STAGES];
    logic [FRAC_BITS-1:0] quo_reg  [0:DIV_STAGES];
    logic [FRAC_BITS-1:0] quo_next [0:DIV_STAGES];
    logic                 neg_reg  [0:DIV_STAGES];
    logic                 neg_next [0:DIV_STAGES];
    logic                 zero_reg [0:DIV_STAGES];
    logic                 zero_next[0:DIV_STAGES];
    logic                 sat_reg  [0:DIV_STAGES];
    logic                 sat_next [0:DIV_STAGES];

    // Square and cube stages
    logic [NW-1:0] n_next;
    logic [NW-1:0] n_reg;
    logic [PW-1:0] sq_full_next;
    logic [PW-1:0] sq_full_reg;
    logic          sq_neg_reg;
    logic [NW-1:0] sq;
    logic [PW-1:0] cube_full_next;
    logic [PW-1:0] cube_full_reg;
    logic          cube_neg_reg;
    logic [NW-1:0] cube_mag;

    logic [8:0] off;
    logic [7:0] mag;

    // Centre the reading, flag deadzone and saturation, seed the divider
    always_comb
    begin : div_steps
        logic [7:0]           r;
        logic [FRAC_BITS-1:0] q;
        logic [8:0]           r2;
        off = {1'b0, raw} - {1'b0, cfg.axis_center};
        mag = off[8] ? (~off[7:0] + 8'd1) : off[7:0];
        rem_next[0]  = mag;
        quo_next[0]  = '0;
        neg_next[0]  = off[8];
        zero_next[0] = (mag < cfg.deadzone) || (mag == 8'd0);
        sat_next[0]  = (cfg.full_scale == 8'd0) || (mag >= cfg.full_scale);

        // Long division of offset * 2^FRAC_BITS by full scale, DIV_BITS_PER_STAGE bits a stage
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            r  = rem_reg[j-1];
            q  = quo_reg[j-1];
            r2 = '0;
            for (int b = 0; b < BPS; b++)
            begin
                if ((j - 1) * BPS + b < FRAC_BITS)
                begin
                    r2 = {r, 1'b0};
                    if (r2 >= {1'b0, cfg.full_scale})
                    begin
                        r2 = r2 - {1'b0, cfg.full_scale};
                        q  = {q[FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        q  = {q[FRAC_BITS-2:0], 1'b0};
                    end
                    r = r2[7:0];
                end
            end
            rem_next[j]  = r;
            quo_next[j]  = q;
            neg_next[j]  = neg_reg[j-1];
            zero_next[j] = zero_reg[j-1];
            sat_next[j]  = sat_reg[j-1];
        end
    end

    // Advance the front end and divider stages
    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
                neg_reg[j]  <= neg_next[j];
                zero_reg[j] <= zero_next[j];
                sat_reg[j]  <= sat_next[j];
            end
        end
    end

    // Pick the normalised value and square it
    always_comb
    begin
        if (zero_reg[DIV_STAGES])
            n_next = '0;
        else if (sat_reg[DIV_STAGES])
            n_next = ONE;
        else
            n_next = {1'b0, quo_reg[DIV_STAGES]};
        sq_full_next = PW'(n_next) * PW'(n_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_STAGES+1])
        begin
            n_reg       <= n_next;
            sq_full_reg <= sq_full_next;
            sq_neg_reg  <= neg_reg[DIV_STAGES];
        end
    end

    // Multiply the truncated square by the value again
    always_comb
    begin
        sq             = sq_full_reg[FRAC_BITS +: NW];
        cube_full_next = PW'(sq) * PW'(n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_STAGES+2])
        begin
            cube_full_reg <= cube_full_next;
            cube_neg_reg  <= sq_neg_reg;
        end
    end

    // Restore the sign on the truncated cube
    always_comb
    begin
        cube_mag = cube_full_reg[FRAC_BITS +: NW];
        cube     = cube_neg_reg ? -$signed({1'b0, cube_mag}) : $signed({1'b0, cube_mag});
    end

endmodule

/* sv/adm_mix.sv */
module adm_mix
#(
    parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic [1:0]                          en,
    input  logic signed [FRAC_BITS+1:0]         turn,
    input  logic signed [FRAC_BITS+1:0]         fwd,
    input  adm_pkg::cfg_t                       cfg,
    output logic signed [adm_pkg::DRIVE_W-1:0]  left_drive,
    output logic signed [adm_pkg::DRIVE_W-1:0]  right_drive
);

    localparam int NW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 3;
    localparam int MW = NW + adm_pkg::CFG_W;
    localparam logic [NW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [SW-1:0] sum [2];
    logic [SW-1:0]        abs_sum;
    logic [NW-1:0]        mag_next [2];
    logic [NW-1:0]        mag_reg  [2];
    logic                 neg_reg  [2];
    logic [MW-1:0]        prod_next [2];
    logic [MW-1:0]        prod_reg  [2];
    logic                 sneg_reg  [2];
    logic [7:0]           speed_mag [2];
    logic signed [adm_pkg::DRIVE_W-1:0] drive [2];

    // Form both sums, clamp to one and split into sign and magnitude
    always_comb
    begin
        sum[0] = {fwd[FRAC_BITS+1], fwd} + {turn[FRAC_BITS+1], turn};
        sum[1] = {fwd[FRAC_BITS+1], fwd} - {turn[FRAC_BITS+1], turn};
        abs_sum = '0;
        for (int i = 0; i < 2; i++)
        begin
            abs_sum     = sum[i][SW-1] ? SW'(-sum[i]) : SW'(sum[i]);
            mag_next[i] = (abs_sum > {2'b00, ONE}) ? ONE : abs_sum[NW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 2; i++)
            begin
                mag_reg[i] <= mag_next[i];
                neg_reg[i] <= sum[i][SW-1];
            end
        end
    end

    // Scale by top speed
    always_comb
    begin
        for (int i = 0; i < 2; i++)
            prod_next[i] = MW'(mag_reg[i]) * MW'(cfg.top_speed);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 2; i++)
            begin
                prod_reg[i] <= prod_next[i];
                sneg_reg[i] <= neg_reg[i];
            end
        end
    end

    // Truncate toward zero and restore the sign
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            speed_mag[i] = prod_reg[i][FRAC_BITS +: 8];
            drive[i]     = sneg_reg[i] ? -$signed({1'b0, speed_mag[i]})
                                       : $signed({1'b0, speed_mag[i]});
        end
    end

    assign left_drive  = drive[0];
    assign right_drive = drive[1];

endmodule

/* sv/arcade_drive_mixer_unit.sv */
// Channel   Signals                      Payload
// s_        s_tvalid s_tready s_tdata    joy_x, joy_y (8 bit unsigned each)
// m_        m_tvalid m_tready m_tdata    left_drive, right_drive (9 bit signed each)
// cfg_      cfg_we cfg_index cfg_data    axis_center, deadzone, full_scale, top_speed
//
// While m_tready is high, one sample a cycle is taken in and one result a cycle given out.
// The pipeline depth is set by the divider stages, which resolve four quotient
// bits each.
// Reset clears the stage valid bits and loads the register defaults.
// A stage holds while its successor is full and stalled; s_tready stays high
// as long as any stage is empty, so a waiting result does not block input.

`include "arcade_drive_mixer_unit_assert.svh"

module arcade_drive_mixer_unit
#(
    parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adm_pkg::IN_DATA_W-1:0]     s_tdata,   // joy_x[7:0], joy_y[15:8]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adm_pkg::OUT_DATA_W-1:0]    m_tdata,   // left_drive[8:0],
                                                         // right_drive[17:9], zeros
    input  logic                              cfg_we,
    input  logic [adm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DIV_STAGES   = (FRAC_BITS + adm_pkg::DIV_BITS_PER_STAGE - 1)
                                  / adm_pkg::DIV_BITS_PER_STAGE;
    localparam int SHAPE_STAGES = DIV_STAGES + 3;
    localparam int NS           = SHAPE_STAGES + 3;
    localparam int OUT_PAD      = adm_pkg::OUT_DATA_W - 2 * adm_pkg::DRIVE_W;

    adm_pkg::cfg_t cfg_reg;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    logic signed [FRAC_BITS+1:0]           turn;
    logic signed [FRAC_BITS+1:0]           fwd;
    logic signed [adm_pkg::DRIVE_W-1:0]    left_drive;
    logic signed [adm_pkg::DRIVE_W-1:0]    right_drive;
    logic [adm_pkg::DRIVE_W-1:0]           left_reg;
    logic [adm_pkg::DRIVE_W-1:0]           right_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_center <= adm_pkg::AXIS_CENTER_RST;
            cfg_reg.deadzone    <= adm_pkg::DEADZONE_RST;
            cfg_reg.full_scale  <= adm_pkg::FULL_SCALE_RST;
            cfg_reg.top_speed   <= adm_pkg::TOP_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                adm_pkg::REG_AXIS_CENTER: cfg_reg.axis_center <= cfg_data;
                adm_pkg::REG_DEADZONE:    cfg_reg.deadzone    <= cfg_data;
                adm_pkg::REG_FULL_SCALE:  cfg_reg.full_scale  <= cfg_data;
                adm_pkg::REG_TOP_SPEED:   cfg_reg.top_speed   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves on
    assign en[NS] = m_tready;
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next = {v_reg[NS-2:0], s_tvalid};

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // Shape the turn and forward axes
    adm_shape #(.FRAC_BITS(FRAC_BITS)) u_shape_x
    (
        .clk  (clk),
        .en   (en[SHAPE_STAGES-1:0]),
        .raw  (s_tdata[7:0]),
        .cfg  (cfg_reg),
        .cube (turn)
    );

    adm_shape #(.FRAC_BITS(FRAC_BITS)) u_shape_y
    (
        .clk  (clk),
        .en   (en[SHAPE_STAGES-1:0]),
        .raw  (s_tdata[15:8]),
        .cfg  (cfg_reg),
        .cube (fwd)
    );

    // Mix and scale to motor drive
    adm_mix #(.FRAC_BITS(FRAC_BITS)) u_mix
    (
        .clk         (clk),
        .en          (en[SHAPE_STAGES+1:SHAPE_STAGES]),
        .turn        (turn),
        .fwd         (fwd),
        .cfg         (cfg_reg),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

    // Hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            left_reg  <= left_drive;
            right_reg <= right_drive;
        end
    end

    assign m_tdata = {{OUT_PAD{1'b0}}, right_reg, left_reg};

    `ADM_ASSERT_NEXT(a_accept_fills_first, s_tvalid && s_tready, v_reg[0])
    `ADM_ASSERT_NOW(a_full_blocks_input, (&v_reg) && !m_tready, !s_tready)
    `ADM_ASSERT_NOW(a_drive_in_range, m_tvalid, (m_tdata[8:0] != 9'h100) && (m_tdata[17:9] != 9'h100))

endmodule

/* sim/arcade_drive_mixer_unit_check.sv */
`timescale 1ns / 100ps

module arcade_drive_mixer_unit_check
#(
    parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [adm_pkg::IN_DATA_W-1:0]  s_tdata,   // joy_x[7:0], joy_y[15:8]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [adm_pkg::OUT_DATA_W-1:0] m_tdata,   // left_drive[8:0],
                                                      // right_drive[17:9], zeros
    input  logic                           cfg_we,
    input  logic [adm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adm_pkg::CFG_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam longint UNITY = longint'(1) << FRAC_BITS;

    typedef logic signed [adm_pkg::DRIVE_W-1:0] drive_t;

    typedef struct packed {
        drive_t left;
        drive_t right;
    } drive_pair_t;

    adm_pkg::cfg_t cfg_copy;
    drive_pair_t   drive_q [$];
    int            mismatches = 0;
    int            waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // Centre the reading, apply the deadzone, normalise, saturate and cube
    function automatic longint curve_axis(input logic [adm_pkg::RAW_W-1:0] raw);
        longint offset;
        longint mag;
        longint norm;
        longint cube;
        offset = longint'(raw) - longint'(cfg_copy.axis_center);
        mag    = (offset < 0) ? -offset : offset;
        if (mag == 0 || mag < longint'(cfg_copy.deadzone))
            return 0;
        if (cfg_copy.full_scale == '0)
            norm = UNITY;
        else
            norm = (mag << FRAC_BITS) / longint'(cfg_copy.full_scale);
        if (norm > UNITY)
            norm = UNITY;
        cube = (((norm * norm) >> FRAC_BITS) * norm) >> FRAC_BITS;
        return (offset < 0) ? -cube : cube;
    endfunction

    // Clamp a mixed command to full scale and scale by top speed, toward zero
    function automatic drive_t scale_drive(input longint mix);
        longint clamped;
        longint mag;
        clamped = (mix > UNITY) ? UNITY : ((mix < -UNITY) ? -UNITY : mix);
        mag     = (clamped < 0) ? -clamped : clamped;
        mag     = (mag * longint'(cfg_copy.top_speed)) >> FRAC_BITS;
        return drive_t'((clamped < 0) ? -mag : mag);
    endfunction

    // Arcade mix: left is forward plus turn, right is forward minus turn
    function automatic drive_pair_t mix_sample(input logic [adm_pkg::IN_DATA_W-1:0] data);
        drive_pair_t pair;
        longint      turn;
        longint      fwd;
        turn       = curve_axis(data[adm_pkg::RAW_W-1:0]);
        fwd        = curve_axis(data[2*adm_pkg::RAW_W-1:adm_pkg::RAW_W]);
        pair.left  = scale_drive(fwd + turn);
        pair.right = scale_drive(fwd - turn);
        return pair;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare each result transfer, queue each sample, track register writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_pair_t want;
        drive_t      got_left;
        drive_t      got_right;
        if (!rst_n)
        begin
            cfg_copy.axis_center = adm_pkg::AXIS_CENTER_RST;
            cfg_copy.deadzone    = adm_pkg::DEADZONE_RST;
            cfg_copy.full_scale  = adm_pkg::FULL_SCALE_RST;
            cfg_copy.top_speed   = adm_pkg::TOP_SPEED_RST;
            drive_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_left  = m_tdata[adm_pkg::DRIVE_W-1:0];
                got_right = m_tdata[2*adm_pkg::DRIVE_W-1:adm_pkg::DRIVE_W];
                if (drive_q.size() == 0)
                    report($sformatf("drive %0d/%0d with nothing expected",
                                     got_left, got_right));
                else
                begin
                    want = drive_q.pop_front();
                    if (got_left !== want.left)
                        report($sformatf("left_drive %0d, expected %0d",
                                         got_left, want.left));
                    if (got_right !== want.right)
                        report($sformatf("right_drive %0d, expected %0d",
                                         got_right, want.right));
                end
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(mix_sample(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    adm_pkg::REG_AXIS_CENTER: cfg_copy.axis_center = cfg_data;
                    adm_pkg::REG_DEADZONE:    cfg_copy.deadzone    = cfg_data;
                    adm_pkg::REG_FULL_SCALE:  cfg_copy.full_scale  = cfg_data;
                    adm_pkg::REG_TOP_SPEED:   cfg_copy.top_speed   = cfg_data;
                    default:                  ;
                endcase
            end
            waiting <= drive_q.size();
        end
    end

endmodule

/* sim/arcade_drive_mixer_unit_test.sv */
`timescale 1ns / 100ps

module arcade_drive_mixer_unit_test;

    localparam int STALL_CYCLES   = 60;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [adm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [adm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_we = 1'b0;
    adm_pkg::cfg_reg_t              cfg_index = adm_pkg::REG_AXIS_CENTER;
    logic [adm_pkg::CFG_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int send_gap_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;

    adm_pkg::cfg_t cur_cfg = '{axis_center: adm_pkg::AXIS_CENTER_RST,
                               deadzone:    adm_pkg::DEADZONE_RST,
                               full_scale:  adm_pkg::FULL_SCALE_RST,
                               top_speed:   adm_pkg::TOP_SPEED_RST};

    arcade_drive_mixer_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arcade_drive_mixer_unit_check #(.FRAC_BITS(adm_pkg::FRAC_BITS_DEF)) drive_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abort when neither channel has moved a transfer for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL arcade_drive_mixer_unit");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one joystick sample and hold it until the transfer
    task automatic send_sample(input logic [adm_pkg::RAW_W-1:0] joy_x,
                               input logic [adm_pkg::RAW_W-1:0] joy_y);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {joy_y, joy_x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every queued drive result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic write_config(input adm_pkg::cfg_t c);
        cur_cfg   = c;
        cfg_we    <= 1'b1;
        cfg_index <= adm_pkg::REG_AXIS_CENTER;
        cfg_data  <= c.axis_center;
        @(posedge clk);
        cfg_index <= adm_pkg::REG_DEADZONE;
        cfg_data  <= c.deadzone;
        @(posedge clk);
        cfg_index <= adm_pkg::REG_FULL_SCALE;
        cfg_data  <= c.full_scale;
        @(posedge clk);
        cfg_index <= adm_pkg::REG_TOP_SPEED;
        cfg_data  <= c.top_speed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly readings around the centre, some at the deadzone edge, some anywhere
    function automatic logic [adm_pkg::RAW_W-1:0] pick_axis();
        int pick;
        int reach;
        int value;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return adm_pkg::RAW_W'($urandom_range(0, 255));
        if (pick == 2)
        begin
            value = int'(cur_cfg.deadzone) - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                value = -value;
        end
        else
        begin
            reach = int'(cur_cfg.full_scale) + int'(cur_cfg.deadzone) + 8;
            value = int'($urandom_range(0, 2 * reach)) - reach;
        end
        value = value + int'(cur_cfg.axis_center);
        if (value < 0)
            value = 0;
        if (value > 255)
            value = 255;
        return adm_pkg::RAW_W'(value);
    endfunction

    initial
    begin
        adm_pkg::cfg_t next_cfg;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: centre, extremes, deadzone edges, full scale, saturation
        send_gap_pct  = 9;
        recv_idle_pct = 66;
        send_sample(8'd50, 8'd50);
        send_sample(8'd0, 8'd0);
        send_sample(8'd255, 8'd255);
        send_sample(8'd255, 8'd0);
        send_sample(8'd0, 8'd255);
        send_sample(8'd54, 8'd50);
        send_sample(8'd55, 8'd50);
        send_sample(8'd45, 8'd50);
        send_sample(8'd46, 8'd50);
        send_sample(8'd100, 8'd50);
        send_sample(8'd101, 8'd50);
        send_sample(8'd50, 8'd100);
        send_sample(8'd50, 8'd0);

        // No deadzone and zero full scale: any nonzero offset is full deflection
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_config('{axis_center: 8'd50, deadzone: 8'd0, full_scale: 8'd0,
                       top_speed: 8'd255});
        send_sample(8'd50, 8'd50);
        send_sample(8'd51, 8'd50);
        send_sample(8'd50, 8'd49);
        send_sample(8'd255, 8'd255);
        send_sample(8'd0, 8'd255);

        // Widest deadzone, smallest full scale, lowest centre
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_config('{axis_center: 8'd0, deadzone: 8'd255, full_scale: 8'd1,
                       top_speed: 8'd1});
        send_sample(8'd255, 8'd255);
        send_sample(8'd254, 8'd255);
        send_sample(8'd255, 8'd0);

        // Highest centre, largest full scale
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_config('{axis_center: 8'd255, deadzone: 8'd0, full_scale: 8'd255,
                       top_speed: 8'd128});
        send_sample(8'd0, 8'd0);
        send_sample(8'd255, 8'd255);
        send_sample(8'd128, 8'd200);

        // Random phases, each with its own settings and idling pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            next_cfg.axis_center = (phase == 1) ? 8'd0 :
                                   (phase == 2) ? 8'd255 :
                                   adm_pkg::CFG_W'($urandom_range(0, 255));
            next_cfg.deadzone    = (phase == 3) ? 8'd0 :
                                   (phase == 4) ? 8'd255 :
                                   adm_pkg::CFG_W'($urandom_range(0, 40));
            next_cfg.full_scale  = (phase == 5) ? 8'd0 :
                                   (phase == 6) ? 8'd1 :
                                   (phase == 7) ? 8'd255 :
                                   adm_pkg::CFG_W'($urandom_range(1, 120));
            next_cfg.top_speed   = (phase == 0) ? 8'd255 :
                                   (phase == 1) ? 8'd0 :
                                   adm_pkg::CFG_W'($urandom_range(0, 255));
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_config(next_cfg);

            if (phase < 3)
            begin
                send_gap_pct  = 9;
                recv_idle_pct = 66;
            end
            else if (phase < 6)
            begin
                send_gap_pct  = 66;
                recv_idle_pct = 9;
            end
            else
            begin
                send_gap_pct  = 0;
                recv_idle_pct = 0;
            end

            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                // Long receiver hold-off while samples keep coming
                if (phase == 2 && item == 40)
                    hold_req = 1'b1;
                // Sender pause until the pipeline has emptied
                if (phase == 4 && item == 75)
                    drain_results();
                send_sample(pick_axis(), pick_axis());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS arcade_drive_mixer_unit");
        else
            $display("FAIL arcade_drive_mixer_unit");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/adm_pkg.sv
sv/adm_shape.sv
sv/adm_mix.sv
sv/arcade_drive_mixer_unit.sv
sim/arcade_drive_mixer_unit_check.sv
sim/arcade_drive_mixer_unit_test.sv
